@@ sv/tlbs_pkg.sv @@
// Shared field widths and command codes for the searchable table block.
package tlbs_pkg;

  localparam int MODE_W  = 2;
  localparam int INDEX_W = 8;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 9;
  localparam int POS_W   = 8;

  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BINARY = 2'd2;

endpackage

@@ sv/tlbs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
module tlbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/table_linear_binary_search_core.sv @@
// Searchable table of signed words with write, linear search and binary search.
//
// The table lives in one RAM of TABLE_DEPTH 32-bit words with a registered
// read. A write transaction (mode 0) stores its value in the cycle it is
// accepted; an index at or beyond TABLE_DEPTH is dropped, and mode 3 does
// nothing. A linear search (mode 1) streams one read per cycle through the
// single read port over the first N words, N being the element count clipped
// to TABLE_DEPTH, compares each word in the cycle after its read, and stops
// at the first match. A binary search (mode 2) works one probe at a time:
// S_BIN_RD reads the midpoint and S_BIN_CHK compares and narrows the window.
// The S_DONE state then hands the result to the output register. One search
// is worked at a time; the next transaction is accepted once the current one
// has handed its result to the output register, which holds it until taken.
// Writes produce no result. The element count is written through the cfg
// port; the user must write it only while the block is idle, as the block
// itself does not enforce this. Table words never written hold unknown data,
// so searches must cover written entries only.
module table_linear_binary_search_core
  import tlbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [COUNT_W-1:0]        cfg_element_count,
  // input transactions
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic [INDEX_W-1:0]        in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  // result transactions
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [POS_W-1:0]          out_position
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_LIN     = 5'b00010,
    S_BIN_RD  = 5'b00100,
    S_BIN_CHK = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]        count_r;
  logic [CW-1:0]             lim_r, lim_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic                      chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]             chk_idx_r, chk_idx_nxt;
  logic signed [SW-1:0]      low_r, low_nxt;
  logic signed [SW-1:0]      high_r, high_nxt;
  logic [AW-1:0]             mid_r, mid_nxt;
  logic                      res_found_r, res_found_nxt;
  logic [POS_W-1:0]          res_pos_r, res_pos_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;

  logic                      in_acc;
  logic [CW-1:0]             used_cnt;
  logic signed [SW-1:0]      diff;
  logic signed [SW-1:0]      mid_full;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] rd_data;

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state_r == S_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

  // Clip the configured count to the table depth.
  assign used_cnt = (32'(count_r) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_r);

  // Midpoint of the binary window; both bounds are non-negative whenever used.
  assign diff     = high_r - low_r;
  assign mid_full = low_r + (diff >>> 1);

  // Write port: a write transaction goes straight into the table.
  assign wr_en   = in_acc && (in_mode == MODE_WRITE) && (32'(in_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(in_index);

  tlbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    lim_nxt       = lim_r;
    key_nxt       = key_r;
    i_nxt         = i_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = 1'b0;
    rd_addr       = mid_full[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt     = in_value;
          lim_nxt     = used_cnt;
          i_nxt       = '0;
          chk_vld_nxt = 1'b0;
          low_nxt     = '0;
          high_nxt    = $signed({1'b0, used_cnt}) - SW'(1);
          if (in_mode == MODE_LINEAR) begin
            state_nxt = S_LIN;
          end else if (in_mode == MODE_BINARY) begin
            state_nxt = S_BIN_RD;
          end
        end
      end

      S_LIN: begin
        // Issue the next read while comparing the word read last cycle.
        rd_en       = (i_r < lim_r);
        rd_addr     = i_r[AW-1:0];
        chk_vld_nxt = rd_en;
        chk_idx_nxt = i_r[AW-1:0];
        if (rd_en) begin
          i_nxt = i_r + CW'(1);
        end
        if (chk_vld_r && (rd_data == key_r)) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = POS_W'(chk_idx_r);
          rd_en         = 1'b0;
          chk_vld_nxt   = 1'b0;
          state_nxt     = S_DONE;
        end else if (!rd_en && !chk_vld_r) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_DONE;
        end
      end

      S_BIN_RD: begin
        if (low_r > high_r) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_DONE;
        end else begin
          rd_en     = 1'b1;
          mid_nxt   = mid_full[AW-1:0];
          state_nxt = S_BIN_CHK;
        end
      end

      S_BIN_CHK: begin
        if (rd_data == key_r) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = POS_W'(mid_r);
          state_nxt     = S_DONE;
        end else begin
          if (rd_data < key_r) begin
            low_nxt = $signed(SW'(mid_r)) + SW'(1);
          end else begin
            high_nxt = $signed(SW'(mid_r)) - SW'(1);
          end
          state_nxt = S_BIN_RD;
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_element_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_r       <= lim_nxt;
    key_r       <= key_nxt;
    i_r         <= i_nxt;
    chk_idx_r   <= chk_idx_nxt;
    low_r       <= low_nxt;
    high_r      <= high_nxt;
    mid_r       <= mid_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

endmodule
